FILE: rtl/mdt_pkg.sv
// ----------------------------------------------------------------------------
// mdt_pkg
// Shared types and constants for the multi-slot deadline timer.
// ----------------------------------------------------------------------------
package mdt_pkg;

  localparam int SLOTS   = 16;
  localparam int MAX_OUT = 16;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);
  localparam int NOW_W   = 48;
  localparam int DL_W    = 49;
  localparam int IVL_W   = 31;
  localparam int TAG_W   = 32;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CREATED    = 3'd0,
    ST_FULL       = 3'd1,
    ST_FREED      = 3'd2,
    ST_FIRED      = 3'd3,
    ST_NONE_FIRED = 3'd4,
    ST_NEXT_DUE   = 3'd5,
    ST_NONE_LIVE  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMD,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [3:0]       slot;
    logic [IVL_W-1:0] interval;
    logic             repeat_mode;
    logic [TAG_W-1:0] tag;
    logic [NOW_W-1:0] now_time;
  } mdt_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [3:0]       slot_out;
    logic [TAG_W-1:0] tag_out;
    logic [IVL_W-1:0] remaining;
    logic             last;
  } mdt_out_t;

  typedef struct packed {
    logic             rep;
    logic [IVL_W-1:0] interval;
    logic [DL_W-1:0]  deadline;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mdt_wr_t;

  typedef struct packed {
    logic     vld;
    mdt_out_t word;
  } mdt_push_t;

endpackage

FILE: rtl/mdt_slot_ram.sv
// ----------------------------------------------------------------------------
// mdt_slot_ram
// Slot entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mdt_slot_ram (
  input  logic                            clk,
  input  logic [mdt_pkg::IDX_W-1:0]       rd_addr,
  output mdt_pkg::entry_t                 rd_data,
  input  mdt_pkg::mdt_wr_t                wr
);

  mdt_pkg::entry_t mem [mdt_pkg::SLOTS];
  mdt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/mdt_out_reg.sv
// ----------------------------------------------------------------------------
// mdt_out_reg
// Result word register between the controller and the output channel.
// ----------------------------------------------------------------------------
module mdt_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  mdt_pkg::mdt_push_t push,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output mdt_pkg::mdt_out_t  out_data
);

  logic              vld_r;
  logic              vld_nxt;
  mdt_pkg::mdt_out_t word_r;

  assign free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (push.vld) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      word_r <= push.word;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = word_r;

endmodule

FILE: rtl/multi_slot_deadline_timer_unit.sv
// ----------------------------------------------------------------------------
// multi_slot_deadline_timer_unit
// Timer slot table: create, free, tick and next-due query over SLOTS slots.
//
//   channel   ports                          word
//   input     in_valid / in_ready / in_data  mdt_in_t  (one command)
//   output    out_valid / out_ready / out_data mdt_out_t (1..MAX_OUT words)
//
// Create and free answer from S_CMD with one word. Tick and query walk the slot RAM
// one slot per cycle; a tick walk pauses while the output holds a fired word.
// The single-port-read slot RAM sets the walk rate.
// Reset clears the live flags; the slot RAM is not cleared.
// A full output register stalls the walk on the slot being fired.
// ----------------------------------------------------------------------------
module multi_slot_deadline_timer_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mdt_pkg::mdt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mdt_pkg::mdt_out_t out_data
);

  mdt_pkg::state_t                 state_r, state_nxt;
  mdt_pkg::mdt_in_t                item_r;
  logic [mdt_pkg::SLOTS-1:0]       live_r, live_nxt;
  logic [mdt_pkg::IDX_W-1:0]       e_r, e_nxt;
  logic [mdt_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            any_r, any_nxt;
  logic [mdt_pkg::IVL_W-1:0]       best_r, best_nxt;
  logic                            pend_vld_r, pend_vld_nxt;
  mdt_pkg::mdt_out_t               pend_r, pend_nxt;

  logic [mdt_pkg::IDX_W-1:0]       rd_addr;
  mdt_pkg::entry_t                 rd_data;
  mdt_pkg::mdt_wr_t                wr;
  mdt_pkg::mdt_push_t              push;
  logic                            out_free;

  logic [mdt_pkg::DL_W-1:0]        now49;
  logic [mdt_pkg::DL_W-1:0]        scan_dl;
  logic [mdt_pkg::DL_W-1:0]        create_dl;
  logic [mdt_pkg::DL_W-1:0]        rem49;
  logic [mdt_pkg::IVL_W-1:0]       rem_sat;
  logic                            live_e;
  logic                            due;
  logic                            free_found;
  logic [mdt_pkg::IDX_W-1:0]       free_idx;
  logic                            advance;

  function automatic mdt_pkg::mdt_out_t mk_word(
    input logic [2:0]                status,
    input logic [3:0]                slot,
    input logic [mdt_pkg::TAG_W-1:0] tag,
    input logic [mdt_pkg::IVL_W-1:0] rem,
    input logic                      last
  );
    mdt_pkg::mdt_out_t w;
    w.status    = status;
    w.slot_out  = slot;
    w.tag_out   = tag;
    w.remaining = rem;
    w.last      = last;
    return w;
  endfunction

  mdt_slot_ram u_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  mdt_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign now49     = {1'b0, item_r.now_time};
  assign scan_dl   = now49 + mdt_pkg::DL_W'(rd_data.interval);
  assign create_dl = now49 + mdt_pkg::DL_W'(item_r.interval);
  assign rem49     = (rd_data.deadline > now49) ? (rd_data.deadline - now49) : '0;
  assign rem_sat   = (|rem49[mdt_pkg::DL_W-1:mdt_pkg::IVL_W]) ? '1
                                                                : rem49[mdt_pkg::IVL_W-1:0];
  assign live_e    = live_r[e_r];
  assign due       = live_e && (now49 >= rd_data.deadline)
                     && (cnt_r < mdt_pkg::CNT_W'(mdt_pkg::MAX_OUT));

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = mdt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_found = 1'b1;
        free_idx   = mdt_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    advance      = 1'b1;
    state_nxt    = state_r;
    live_nxt     = live_r;
    e_nxt        = e_r;
    cnt_nxt      = cnt_r;
    any_nxt      = any_r;
    best_nxt     = best_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    rd_addr      = e_r;
    wr           = '0;
    push         = '0;
    in_ready     = 1'b0;

    case (state_r)
      mdt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = '0;
        if (in_valid) begin
          e_nxt        = '0;
          cnt_nxt      = '0;
          any_nxt      = 1'b0;
          best_nxt     = '0;
          pend_vld_nxt = 1'b0;
          if (in_data.action == mdt_pkg::ACT_TICK || in_data.action == mdt_pkg::ACT_QUERY) begin
            state_nxt = mdt_pkg::S_SCAN;
          end else begin
            state_nxt = mdt_pkg::S_CMD;
          end
        end
      end

      mdt_pkg::S_CMD: begin
        if (out_free) begin
          push.vld  = 1'b1;
          state_nxt = mdt_pkg::S_IDLE;
          if (item_r.action == mdt_pkg::ACT_CREATE) begin
            if (free_found) begin
              push.word              = mk_word(mdt_pkg::ST_CREATED, 4'(free_idx), '0, '0, 1'b1);
              live_nxt[free_idx]     = 1'b1;
              wr.en                  = 1'b1;
              wr.addr                = free_idx;
              wr.data.rep            = item_r.repeat_mode;
              wr.data.interval       = item_r.interval;
              wr.data.deadline       = create_dl;
              wr.data.tag            = item_r.tag;
            end else begin
              push.word = mk_word(mdt_pkg::ST_FULL, '0, '0, '0, 1'b1);
            end
          end else begin
            push.word = mk_word(mdt_pkg::ST_FREED, item_r.slot, '0, '0, 1'b1);
            if (32'(item_r.slot) < mdt_pkg::SLOTS) begin
              live_nxt[mdt_pkg::IDX_W'(item_r.slot)] = 1'b0;
            end
          end
        end
      end

      mdt_pkg::S_SCAN: begin
        if (item_r.action == mdt_pkg::ACT_TICK) begin
          if (due) begin
            if (pend_vld_r && !out_free) begin
              advance = 1'b0;
            end else begin
              push.vld     = pend_vld_r;
              push.word    = pend_r;
              pend_vld_nxt = 1'b1;
              pend_nxt     = mk_word(mdt_pkg::ST_FIRED, 4'(e_r), rd_data.tag, '0, 1'b0);
              cnt_nxt      = cnt_r + 1'b1;
              if (rd_data.rep) begin
                wr.en            = 1'b1;
                wr.addr          = e_r;
                wr.data          = rd_data;
                wr.data.deadline = scan_dl;
              end else begin
                live_nxt[e_r] = 1'b0;
              end
            end
          end
        end else if (live_e) begin
          any_nxt = 1'b1;
          if (!any_r || rem_sat < best_r) begin
            best_nxt = rem_sat;
          end
        end
        if (advance) begin
          if (e_r == mdt_pkg::LAST_IDX) begin
            state_nxt = mdt_pkg::S_DONE;
          end else begin
            e_nxt   = e_r + 1'b1;
            rd_addr = e_r + 1'b1;
          end
        end
      end

      mdt_pkg::S_DONE: begin
        if (out_free) begin
          push.vld     = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = mdt_pkg::S_IDLE;
          if (item_r.action == mdt_pkg::ACT_TICK) begin
            if (pend_vld_r) begin
              push.word      = pend_r;
              push.word.last = 1'b1;
            end else begin
              push.word = mk_word(mdt_pkg::ST_NONE_FIRED, '0, '0, '0, 1'b1);
            end
          end else if (any_r) begin
            push.word = mk_word(mdt_pkg::ST_NEXT_DUE, '0, '0, best_r, 1'b1);
          end else begin
            push.word = mk_word(mdt_pkg::ST_NONE_LIVE, '0, '0, '0, 1'b1);
          end
        end
      end

      default: begin
        state_nxt = mdt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mdt_pkg::S_IDLE;
      live_r     <= '0;
      e_r        <= '0;
      cnt_r      <= '0;
      any_r      <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      live_r     <= live_nxt;
      e_r        <= e_nxt;
      cnt_r      <= cnt_nxt;
      any_r      <= any_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    best_r <= best_nxt;
    pend_r <= pend_nxt;
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> out_free)
    else $error("word pushed into a full output register");

  a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (state_r == mdt_pkg::S_SCAN || state_r == mdt_pkg::S_DONE))
    else $error("held fire word outside a tick walk");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mdt_pkg::CNT_W'(mdt_pkg::MAX_OUT))
    else $error("fire count above cap");

  a_ram_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && state_r == mdt_pkg::S_SCAN && e_r != mdt_pkg::LAST_IDX) |-> (wr.addr != rd_addr))
    else $error("slot RAM read and write hit the same entry");

endmodule
